// File: hw/rtl/tsnb_pkg.sv
// shared types, codes and channel math of the texture sampler
package tsnb_pkg;

   localparam logic [7:0]  CFG_WIDTH     = 8'd0;
   localparam logic [7:0]  CFG_HEIGHT    = 8'd1;
   localparam logic        CMD_WRITE     = 1'b0;
   localparam logic        CMD_SAMPLE    = 1'b1;
   localparam logic        MODE_NEAREST  = 1'b0;
   localparam logic        MODE_BILINEAR = 1'b1;
   localparam logic [15:0] FRAC_HALF     = 16'h8000;
   localparam logic [16:0] FRAC_ONE      = 17'h10000;

   typedef struct packed {
      logic        valid;
      logic        mode;
      logic        oor;
      logic [15:0] fx;
      logic [15:0] fy;
   } smp_ctl_type;

   function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [15:0] f);
      logic [25:0] acc;
      acc = 26'(a) * 26'(FRAC_ONE - 17'(f)) + 26'(b) * 26'(f) + 26'(FRAC_HALF);
      return acc[23:16];
   endfunction

   function automatic logic [31:0] rotr8(input logic [31:0] w);
      return {w[7:0], w[31:8]};
   endfunction

endpackage

// File: hw/rtl/tsnb_ram.sv
// generic single write, dual read ram with registered read data
module tsnb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd0_ff;
   logic [WIDTH-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd0_ff <= mem[rd_addr0];
         rd1_ff <= mem[rd_addr1];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// File: hw/rtl/tsnb_coord.sv
// coordinate scaling, rounding, edge clamp and row base stages
module tsnb_coord #(
   parameter int SIDE_W = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic [SIDE_W-1:0]          wid,
   input  logic [SIDE_W-1:0]          hgt,
   input  logic                       in_valid,
   input  logic                       in_cmd,
   input  logic [15:0]                in_addr,
   input  logic [31:0]                in_word,
   input  logic [16:0]                in_u,
   input  logic [16:0]                in_v,
   input  logic                       in_mode,
   output tsnb_pkg::smp_ctl_type      ctl,
   output logic                       wr_valid,
   output logic [15:0]                wr_addr,
   output logic [31:0]                wr_word,
   output logic [2*SIDE_W-1:0]        base0,
   output logic [2*SIDE_W-1:0]        base1,
   output logic [SIDE_W-1:0]          col0,
   output logic [SIDE_W-1:0]          col1
);

   localparam int PW = SIDE_W + 17;
   localparam int XW = SIDE_W + 2;
   localparam int BW = 2 * SIDE_W;

   // stage 1: scale
   logic            s1_valid_ff, s1_cmd_ff, s1_mode_ff;
   logic [15:0]     s1_addr_ff;
   logic [31:0]     s1_word_ff;
   logic [PW-1:0]   s1_px_ff, s1_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_cmd_ff  <= in_cmd;
         s1_mode_ff <= in_mode;
         s1_addr_ff <= in_addr;
         s1_word_ff <= in_word;
         s1_px_ff   <= PW'(wid) * PW'(in_u);
         s1_py_ff   <= PW'(hgt) * PW'(in_v);
      end
   end

   // stage 2: texel columns and rows
   logic [XW-1:0]   x0, y0, xn, yn, x1, y1, w_x, h_x;
   logic [15:0]     fx, fy;
   logic            oor_in;
   logic [SIDE_W-1:0] c0_in, c1_in, r0_in, r1_in;

   always_comb begin
      w_x = XW'(wid);
      h_x = XW'(hgt);
      x0  = XW'(s1_px_ff[PW-1:16]);
      y0  = XW'(s1_py_ff[PW-1:16]);
      fx  = s1_px_ff[15:0];
      fy  = s1_py_ff[15:0];
      xn  = x0 + XW'(fx > tsnb_pkg::FRAC_HALF);
      yn  = y0 + XW'(fy > tsnb_pkg::FRAC_HALF);
      x1  = (x0 + XW'(1) >= w_x) ? x0 : x0 + XW'(1);
      y1  = (y0 + XW'(1) >= h_x) ? y0 : y0 + XW'(1);
      if (s1_mode_ff == tsnb_pkg::MODE_NEAREST) begin
         oor_in = (xn >= w_x) || (yn >= h_x);
         c0_in  = xn[SIDE_W-1:0];
         r0_in  = yn[SIDE_W-1:0];
      end else begin
         oor_in = (x0 >= w_x) || (y0 >= h_x);
         c0_in  = x0[SIDE_W-1:0];
         r0_in  = y0[SIDE_W-1:0];
      end
      c1_in = x1[SIDE_W-1:0];
      r1_in = y1[SIDE_W-1:0];
   end

   tsnb_pkg::smp_ctl_type s2_ctl_ff;
   logic            s2_wr_ff;
   logic [15:0]     s2_addr_ff;
   logic [31:0]     s2_word_ff;
   logic [SIDE_W-1:0] s2_c0_ff, s2_c1_ff, s2_r0_ff, s2_r1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
         s2_wr_ff  <= 1'b0;
      end else if (en) begin
         s2_ctl_ff.valid <= s1_valid_ff && (s1_cmd_ff == tsnb_pkg::CMD_SAMPLE);
         s2_ctl_ff.mode  <= s1_mode_ff;
         s2_ctl_ff.oor   <= oor_in;
         s2_ctl_ff.fx    <= fx;
         s2_ctl_ff.fy    <= fy;
         s2_wr_ff        <= s1_valid_ff && (s1_cmd_ff == tsnb_pkg::CMD_WRITE);
      end
      if (en) begin
         s2_addr_ff <= s1_addr_ff;
         s2_word_ff <= s1_word_ff;
         s2_c0_ff   <= c0_in;
         s2_c1_ff   <= c1_in;
         s2_r0_ff   <= r0_in;
         s2_r1_ff   <= r1_in;
      end
   end

   // stage 3: row base addresses
   tsnb_pkg::smp_ctl_type s3_ctl_ff;
   logic            s3_wr_ff;
   logic [15:0]     s3_addr_ff;
   logic [31:0]     s3_word_ff;
   logic [BW-1:0]   s3_b0_ff, s3_b1_ff;
   logic [SIDE_W-1:0] s3_c0_ff, s3_c1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
         s3_wr_ff  <= 1'b0;
      end else if (en) begin
         s3_ctl_ff <= s2_ctl_ff;
         s3_wr_ff  <= s2_wr_ff;
      end
      if (en) begin
         s3_addr_ff <= s2_addr_ff;
         s3_word_ff <= s2_word_ff;
         s3_b0_ff   <= BW'(s2_r0_ff) * BW'(wid);
         s3_b1_ff   <= BW'(s2_r1_ff) * BW'(wid);
         s3_c0_ff   <= s2_c0_ff;
         s3_c1_ff   <= s2_c1_ff;
      end
   end

   assign ctl      = s3_ctl_ff;
   assign wr_valid = s3_wr_ff;
   assign wr_addr  = s3_addr_ff;
   assign wr_word  = s3_word_ff;
   assign base0    = s3_b0_ff;
   assign base1    = s3_b1_ff;
   assign col0     = s3_c0_ff;
   assign col1     = s3_c1_ff;

endmodule

// File: hw/rtl/tsnb_blend.sv
// per channel horizontal and vertical blend stages and the result register
module tsnb_blend (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  tsnb_pkg::smp_ctl_type ctl,
   input  logic [31:0]           lt,
   input  logic [31:0]           rt,
   input  logic [31:0]           lb,
   input  logic [31:0]           rb,
   output logic                  out_valid,
   output logic [31:0]           out_color,
   output logic                  out_oor
);

   logic [31:0] top_in, bot_in;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         top_in[8*c +: 8] = tsnb_pkg::lerp8(lt[8*c +: 8], rt[8*c +: 8], ctl.fx);
         bot_in[8*c +: 8] = tsnb_pkg::lerp8(lb[8*c +: 8], rb[8*c +: 8], ctl.fx);
      end
   end

   tsnb_pkg::smp_ctl_type h_ctl_ff;
   logic [31:0] h_top_ff, h_bot_ff, h_lt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ctl_ff <= '0;
      end else if (en) begin
         h_ctl_ff <= ctl;
      end
      if (en) begin
         h_top_ff <= top_in;
         h_bot_ff <= bot_in;
         h_lt_ff  <= lt;
      end
   end

   logic [31:0] mix, color_in;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         mix[8*c +: 8] = tsnb_pkg::lerp8(h_top_ff[8*c +: 8], h_bot_ff[8*c +: 8],
                                         h_ctl_ff.fy);
      end
      if (h_ctl_ff.oor) begin
         color_in = '0;
      end else if (h_ctl_ff.mode == tsnb_pkg::MODE_BILINEAR) begin
         color_in = tsnb_pkg::rotr8(mix);
      end else begin
         color_in = tsnb_pkg::rotr8(h_lt_ff);
      end
   end

   logic        valid_ff;
   logic [31:0] color_ff;
   logic        oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= h_ctl_ff.valid;
      end
      if (en) begin
         color_ff <= color_in;
         oor_ff   <= h_ctl_ff.oor;
      end
   end

   assign out_valid = valid_ff;
   assign out_color = color_ff;
   assign out_oor   = oor_ff;

endmodule

// File: hw/rtl/texture_sampler_nearest_bilinear_core.sv
// texture sampler top level: config registers, texel store and pipeline wiring
//
// Six-stage pipeline that takes one write or sample beat per cycle while no result is
// stalled. Each sample gets one result beat, held until the result side takes it.
// Scaling, rounding, row base multiply, store read, horizontal blend and vertical
// blend each own a stage. The store is held twice, every write going to both copies,
// so that each copy's two read ports together yield all four corner texels at once.
// The whole pipeline stalls together while a result waits to be taken.
module texture_sampler_nearest_bilinear_core #(
   parameter int MAX_SIDE    = 256,
   parameter int STORE_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_texel_addr,
   input  logic [31:0] req_texel_word,
   input  logic [16:0] req_u_coord,
   input  logic [16:0] req_v_coord,
   input  logic        req_filter_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_color,
   output logic        rsp_out_of_range,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [8:0]  csr_data
);

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int BW     = 2 * SIDE_W;
   localparam int AW     = $clog2(STORE_WORDS);
   localparam logic [31:0] STORE_LIM = 32'(STORE_WORDS);
   localparam int RST_SIDE = (MAX_SIDE < 256) ? MAX_SIDE : 256;

   logic adv;

   // config registers hold the effective side
   logic [SIDE_W-1:0] wid_ff, hgt_ff;
   logic [31:0]       side_raw;
   logic [SIDE_W-1:0] side_in;

   always_comb begin
      side_raw = 32'(csr_data);
      if (side_raw == 32'd0) begin
         side_raw = 32'd1;
      end else if (side_raw > 32'(MAX_SIDE)) begin
         side_raw = 32'(MAX_SIDE);
      end
      side_in = side_raw[SIDE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wid_ff <= SIDE_W'(RST_SIDE);
         hgt_ff <= SIDE_W'(RST_SIDE);
      end else if (csr_valid) begin
         if (csr_index == tsnb_pkg::CFG_WIDTH) begin
            wid_ff <= side_in;
         end else if (csr_index == tsnb_pkg::CFG_HEIGHT) begin
            hgt_ff <= side_in;
         end
      end
   end

   assign csr_ready = 1'b1;

   // coordinate stages
   tsnb_pkg::smp_ctl_type s3_ctl;
   logic              s3_wr;
   logic [15:0]       s3_addr;
   logic [31:0]       s3_word;
   logic [BW-1:0]     base0, base1;
   logic [SIDE_W-1:0] col0, col1;

   tsnb_coord #(.SIDE_W(SIDE_W)) u_coord (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .wid      (wid_ff),
      .hgt      (hgt_ff),
      .in_valid (req_valid),
      .in_cmd   (req_cmd),
      .in_addr  (req_texel_addr),
      .in_word  (req_texel_word),
      .in_u     (req_u_coord),
      .in_v     (req_v_coord),
      .in_mode  (req_filter_mode),
      .ctl      (s3_ctl),
      .wr_valid (s3_wr),
      .wr_addr  (s3_addr),
      .wr_word  (s3_word),
      .base0    (base0),
      .base1    (base1),
      .col0     (col0),
      .col1     (col1)
   );

   // store access
   logic [31:0] a00, a01, a10, a11, wa;
   logic [3:0]  miss_in;
   logic        wen;

   always_comb begin
      a00 = 32'(base0) + 32'(col0);
      a01 = 32'(base0) + 32'(col1);
      a10 = 32'(base1) + 32'(col0);
      a11 = 32'(base1) + 32'(col1);
      wa  = 32'(s3_addr);
      miss_in = {a11 >= STORE_LIM, a10 >= STORE_LIM, a01 >= STORE_LIM, a00 >= STORE_LIM};
      wen = adv && s3_wr && (wa < STORE_LIM);
   end

   logic [31:0] q_lt, q_rt, q_lb, q_rb;

   tsnb_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_ram_top (
      .clock    (clock),
      .wr_en    (wen),
      .wr_addr  (wa[AW-1:0]),
      .wr_data  (s3_word),
      .rd_en    (adv),
      .rd_addr0 (a00[AW-1:0]),
      .rd_addr1 (a01[AW-1:0]),
      .rd_data0 (q_lt),
      .rd_data1 (q_rt)
   );

   tsnb_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_ram_bot (
      .clock    (clock),
      .wr_en    (wen),
      .wr_addr  (wa[AW-1:0]),
      .wr_data  (s3_word),
      .rd_en    (adv),
      .rd_addr0 (a10[AW-1:0]),
      .rd_addr1 (a11[AW-1:0]),
      .rd_data0 (q_lb),
      .rd_data1 (q_rb)
   );

   tsnb_pkg::smp_ctl_type s4_ctl_ff;
   logic [3:0] s4_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
      end else if (adv) begin
         s4_ctl_ff <= s3_ctl;
      end
      if (adv) begin
         s4_miss_ff <= miss_in;
      end
   end

   // addresses past the store read as zero
   logic [31:0] lt, rt, lb, rb;

   assign lt = s4_miss_ff[0] ? 32'd0 : q_lt;
   assign rt = s4_miss_ff[1] ? 32'd0 : q_rt;
   assign lb = s4_miss_ff[2] ? 32'd0 : q_lb;
   assign rb = s4_miss_ff[3] ? 32'd0 : q_rb;

   tsnb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .ctl       (s4_ctl_ff),
      .lt        (lt),
      .rt        (rt),
      .lb        (lb),
      .rb        (rb),
      .out_valid (rsp_valid),
      .out_color (rsp_color),
      .out_oor   (rsp_out_of_range)
   );

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

endmodule

// File: hw/rtl/tsnb_checker.sv
// port level checks for the texture sampler, bound to the top level
module tsnb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_cmd,
   input logic [15:0] req_texel_addr,
   input logic [31:0] req_texel_word,
   input logic [16:0] req_u_coord,
   input logic [16:0] req_v_coord,
   input logic        req_filter_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_color,
   input logic        rsp_out_of_range,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [7:0]  csr_index,
   input logic [8:0]  csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color)
         && $stable(rsp_out_of_range))
      else $error("result beat changed while stalled");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_color == 32'd0)
      else $error("out of range result with nonzero color");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind texture_sampler_nearest_bilinear_core tsnb_checker u_tsnb_checker (.*);

// File: verif/tb_texture_sampler_nearest_bilinear_core.sv
// testbench for the texture sampler: store fill, config phases, directed and random samples
`timescale 1ns / 100ps

module tb_texture_sampler_nearest_bilinear_core;

   localparam int  STORE_DEPTH = 65536;
   localparam int  FILL_WORDS  = 512;
   localparam int  SIDE_MAX    = 256;
   localparam int  CYCLE_LIMIT = 3000000;

   class texel_color_checker;
      logic [31:0] texels [STORE_DEPTH];
      logic [8:0]  width_reg;
      logic [8:0]  height_reg;
      logic [31:0] color_q [$];
      logic        oor_q [$];
      int          errors;

      function void reset_state();
         width_reg  = 9'd256;
         height_reg = 9'd256;
         errors     = 0;
      endfunction

      function void write_reg(logic [7:0] idx, logic [8:0] data);
         if (idx == tsnb_pkg::CFG_WIDTH) width_reg = data;
         else if (idx == tsnb_pkg::CFG_HEIGHT) height_reg = data;
      endfunction

      function longint side(logic [8:0] r);
         if (r == 0) return 1;
         if (r > SIDE_MAX) return SIDE_MAX;
         return r;
      endfunction

      function logic [31:0] texel_at(longint addr);
         if (addr >= STORE_DEPTH) return 32'd0;
         return texels[addr];
      endfunction

      function logic [7:0] blend(logic [7:0] a, logic [7:0] b, longint f);
         longint acc;
         acc = a * (65536 - f) + b * f + 32768;
         return acc[23:16];
      endfunction

      function void note_beat(logic cmd, logic [15:0] addr, logic [31:0] word,
                              logic [16:0] u, logic [16:0] v, logic mode);
         longint w, h, pxf, pyf, x0, y0, x1, y1, fx, fy, px, py;
         logic [31:0] lt, rt, lb, rb, mix, color;
         logic [7:0] top, bot;
         logic oor;
         if (cmd == tsnb_pkg::CMD_WRITE) begin
            texels[addr] = word;
            return;
         end
         w = side(width_reg);
         h = side(height_reg);
         pxf = w * u;
         pyf = h * v;
         x0 = pxf >> 16;
         y0 = pyf >> 16;
         fx = pxf & 16'hffff;
         fy = pyf & 16'hffff;
         color = 32'd0;
         oor = 1'b0;
         if (mode == tsnb_pkg::MODE_NEAREST) begin
            px = x0 + ((fx > 32768) ? 1 : 0);
            py = y0 + ((fy > 32768) ? 1 : 0);
            if (px >= w || py >= h) oor = 1'b1;
            else color = texel_at(w * py + px);
            color = {color[7:0], color[31:8]};
         end else begin
            if (x0 >= w || y0 >= h) begin
               oor = 1'b1;
            end else begin
               x1 = (x0 + 1 >= w) ? x0 : x0 + 1;
               y1 = (y0 + 1 >= h) ? y0 : y0 + 1;
               lt = texel_at(w * y0 + x0);
               rt = texel_at(w * y0 + x1);
               lb = texel_at(w * y1 + x0);
               rb = texel_at(w * y1 + x1);
               for (int sh = 0; sh < 32; sh += 8) begin
                  top = blend(lt[sh +: 8], rt[sh +: 8], fx);
                  bot = blend(lb[sh +: 8], rb[sh +: 8], fx);
                  mix[sh +: 8] = blend(top, bot, fy);
               end
               color = {mix[7:0], mix[31:8]};
            end
         end
         color_q.push_back(color);
         oor_q.push_back(oor);
      endfunction

      function void check_beat(logic [31:0] color, logic oor);
         logic [31:0] exp_color;
         logic exp_oor;
         if (color_q.size() == 0) begin
            $display("%0t: unexpected result beat color %h oor %b", $time, color, oor);
            errors++;
            return;
         end
         exp_color = color_q.pop_front();
         exp_oor   = oor_q.pop_front();
         if (color !== exp_color) begin
            $display("%0t: color expected %h actual %h", $time, exp_color, color);
            errors++;
         end
         if (oor !== exp_oor) begin
            $display("%0t: out_of_range expected %b actual %b", $time, exp_oor, oor);
            errors++;
         end
      endfunction

      function int pending();
         return color_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [15:0] req_texel_addr = '0;
   logic [31:0] req_texel_word = '0;
   logic [16:0] req_u_coord = '0;
   logic [16:0] req_v_coord = '0;
   logic        req_filter_mode = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_color;
   logic        rsp_out_of_range;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [8:0]  csr_data = '0;

   texel_color_checker checker_h = new();
   int  cycles = 0;
   int  stall_left = 0;
   bit  no_gaps = 1'b0;
   bit  rsp_steady = 1'b0;

   texture_sampler_nearest_bilinear_core uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[texture_sampler_nearest_bilinear_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) checker_h.check_beat(rsp_color, rsp_out_of_range);
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_steady) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 9) < 3) begin
         stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                   : $urandom_range(10, 40);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_beat(logic cmd, logic [15:0] addr, logic [31:0] word,
                            logic [16:0] u, logic [16:0] v, logic mode, bit idle_ok);
      int gap;
      gap = 0;
      if (idle_ok && !no_gaps && $urandom_range(0, 9) >= 6)
         gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_texel_addr  <= addr;
      req_texel_word  <= word;
      req_u_coord     <= u;
      req_v_coord     <= v;
      req_filter_mode <= mode;
      do @(posedge clock); while (!req_ready);
      checker_h.note_beat(cmd, addr, word, u, v, mode);
      @(negedge clock);
   endtask

   task automatic sample(logic [16:0] u, logic [16:0] v, logic mode);
      send_beat(tsnb_pkg::CMD_SAMPLE, 16'($urandom), 32'($urandom), u, v, mode, 1'b1);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [8:0] data);
      req_valid <= 1'b0;
      while (checker_h.pending() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      checker_h.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [16:0] rand_coord();
      int k;
      k = $urandom_range(0, 19);
      if (k < 14) return 17'($urandom_range(0, 65535));
      if (k < 16) return 17'd65536;
      if (k < 18) return 17'($urandom_range(0, 131071));
      return 17'($urandom_range(65000, 65536));
   endfunction

   // every phase keeps width times height within the filled part of the store
   task automatic run_phase(logic [8:0] w, logic [8:0] h, int count);
      int k;
      write_csr(tsnb_pkg::CFG_WIDTH, w);
      write_csr(tsnb_pkg::CFG_HEIGHT, h);
      no_gaps    = ($urandom_range(0, 3) == 0);
      rsp_steady = ($urandom_range(0, 3) == 0);
      for (int m = 0; m < 2; m++) begin
         sample(17'd0, 17'd0, m[0]);
         sample(17'd65535, 17'd65535, m[0]);
         sample(17'd65536, 17'd0, m[0]);
         sample(17'd0, 17'd65536, m[0]);
         sample(17'd131071, 17'd131071, m[0]);
         sample(17'd32768, 17'd32768, m[0]);
         sample(17'd32769, 17'd32769, m[0]);
      end
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 9);
         if (k < 2)
            send_beat(tsnb_pkg::CMD_WRITE, 16'($urandom), 32'($urandom), 17'($urandom),
                      17'($urandom), 1'($urandom), 1'b1);
         else
            sample(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
      end
      rsp_steady = 1'b0;
   endtask

   initial begin
      checker_h.reset_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      no_gaps = 1'b1;
      for (int a = 0; a < FILL_WORDS; a++)
         send_beat(tsnb_pkg::CMD_WRITE, a[15:0], 32'($urandom), '0, '0,
                   tsnb_pkg::MODE_NEAREST, 1'b0);
      req_valid <= 1'b0;
      for (int m = 0; m < 2; m++) begin
         sample(17'd0, 17'd0, m[0]);
         sample(17'd65535, 17'd0, m[0]);
      end
      run_phase(9'd256, 9'd2, 120);
      run_phase(9'd1, 9'd1, 80);
      run_phase(9'd0, 9'd0, 80);
      run_phase(9'd511, 9'd2, 120);
      run_phase(9'd2, 9'd300, 120);
      run_phase(9'd3, 9'd5, 120);
      run_phase(9'd17, 9'd30, 120);
      write_csr(8'd2, 9'h1ff);
      write_csr(8'hff, 9'd0);
      run_phase(9'd2, 9'd255, 100);
      req_valid <= 1'b0;
      while (checker_h.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (checker_h.errors == 0)
         $display("[texture_sampler_nearest_bilinear_core] OK");
      else
         $display("[texture_sampler_nearest_bilinear_core] ERROR");
      $finish;
   end

endmodule
